// File: rtl/kinematic_bicycle_step_top_assert.svh
// Assertion macros shared by the RTL. Each use expands to one labeled
// concurrent assertion that is sampled on the rising clock edge and
// switched off while reset is high.
`ifndef KINEMATIC_BICYCLE_STEP_TOP_ASSERT_SVH
`define KINEMATIC_BICYCLE_STEP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/kbs_pkg.sv
package kbs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WSHIFT    = 30 - FRAC_BITS;

   localparam int Z_W     = 34;
   localparam int XY_W    = 33;
   localparam int DIV_NW  = 57;
   localparam int DIV_DW  = 32;
   localparam int PROD_W  = 68;
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 32;

   localparam longint PI_Q30_L   = 64'sd3373259426;
   localparam longint PI_Q       = (PI_Q30_L + (64'sd1 <<< (WSHIFT - 1))) >>> WSHIFT;
   localparam longint TWO_PI_Q   = (2 * PI_Q30_L + (64'sd1 <<< (WSHIFT - 1))) >>> WSHIFT;
   localparam longint SKIP_LIMIT = ((64'sd1 <<< FRAC_BITS) + 9999) / 10000;
   localparam longint STEER_LIM  = 64'sd3 <<< (FRAC_BITS - 1);

   // The heading wrap estimates the period count by a reciprocal multiplication.
   localparam int     HEAD_RECIP_SH = 48;
   localparam longint HEAD_RECIP_L  = (64'sd1 <<< HEAD_RECIP_SH) / TWO_PI_Q;

   localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [XY_W-1:0] GAIN_Q30   = 33'sd652032874;

   localparam logic signed [MUL_B_W-1:0] HEAD_RECIP = MUL_B_W'(HEAD_RECIP_L);
   localparam logic signed [MUL_B_W-1:0] TWO_PI_MUL = MUL_B_W'(TWO_PI_Q);

   localparam logic signed [18:0] HEADING_MAX = 19'(PI_Q);
   localparam logic signed [17:0] STEER_MAX   = 18'(STEER_LIM);

   localparam logic [1:0] CMD_STEP  = 2'd0;
   localparam logic [1:0] CMD_STOP  = 2'd1;
   localparam logic [1:0] CMD_RESET = 2'd2;

   localparam logic [0:0] REG_RADIUS = 1'd0;
   localparam logic [0:0] REG_BASE   = 1'd1;

   localparam logic [19:0] RADIUS_RESET = 20'd16384;
   localparam logic [19:0] BASE_RESET   = 20'd98304;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_STEER_TRIG,
      ST_STEER_WAIT,
      ST_TAN_DIV,
      ST_TAN_WAIT,
      ST_YAW_MUL,
      ST_YAW_DIV,
      ST_YAW_WAIT,
      ST_HEAD_TRIG,
      ST_HEAD_WAIT,
      ST_VX_MUL,
      ST_VXDT_MUL,
      ST_X_UPD,
      ST_VYDT_MUL,
      ST_Y_UPD,
      ST_ADT_MUL,
      ST_SPEED_UPD,
      ST_HEAD_RECIP,
      ST_HEAD_QMUL,
      ST_HEAD_WRAP,
      ST_STEER_MUL,
      ST_STEER_UPD,
      ST_WS_DIV,
      ST_WS_WAIT,
      ST_RESP
   } state_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         5'd0:  r = 34'sd843314857;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043837;
         5'd3:  r = 34'sd133525159;
         5'd4:  r = 34'sd67021687;
         5'd5:  r = 34'sd33543516;
         5'd6:  r = 34'sd16775851;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194283;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048576;
         5'd11: r = 34'sd524288;
         5'd12: r = 34'sd262144;
         5'd13: r = 34'sd131072;
         5'd14: r = 34'sd65536;
         5'd15: r = 34'sd32768;
         5'd16: r = 34'sd16384;
         5'd17: r = 34'sd8192;
         5'd18: r = 34'sd4096;
         5'd19: r = 34'sd2048;
         5'd20: r = 34'sd1024;
         5'd21: r = 34'sd512;
         5'd22: r = 34'sd256;
         5'd23: r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/kbs_req_if.sv
interface kbs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [17:0] step_time;
   logic signed [31:0] wheel_accel;
   logic signed [20:0] steer_rate;

   modport source (output valid, cmd, step_time, wheel_accel, steer_rate, input ready);
   modport sink (input valid, cmd, step_time, wheel_accel, steer_rate, output ready);
endinterface

// File: rtl/kbs_rsp_if.sv
interface kbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [18:0] heading;
   logic signed [17:0] steer_angle;
   logic signed [31:0] speed;
   logic signed [31:0] wheel_speed;
   logic signed [31:0] yaw_rate;
   logic               skipped;

   modport source (output valid, pos_x, pos_y, heading, steer_angle, speed, wheel_speed,
                   yaw_rate, skipped, input ready);
   modport sink (input valid, pos_x, pos_y, heading, steer_angle, speed, wheel_speed,
                 yaw_rate, skipped, output ready);
endinterface

// File: rtl/kbs_cordic.sv
module kbs_cordic #(
   parameter int ITERS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [kbs_pkg::Z_W-1:0]   z_in,
   output logic                             done,
   output logic signed [kbs_pkg::XY_W-1:0]  cos_out,
   output logic signed [kbs_pkg::XY_W-1:0]  sin_out
);
   import kbs_pkg::*;

   localparam int CW = $clog2(ITERS);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in_n;
   logic signed [XY_W-1:0] x_sh, y_sh;
   logic signed [Z_W-1:0]  ang;

   assign x_sh = x_ff >>> cnt_ff;
   assign y_sh = y_ff >>> cnt_ff;
   assign ang  = atan_q30(5'(cnt_ff));

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in_n  = z_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         x_in   = GAIN_Q30;
         y_in   = '0;
         z_in_n = z_in;
      end else if (run_ff) begin
         if (z_ff >= 0) begin
            x_in   = x_ff - y_sh;
            y_in   = y_ff + x_sh;
            z_in_n = z_ff - ang;
         end else begin
            x_in   = x_ff + y_sh;
            y_in   = y_ff - x_sh;
            z_in_n = z_ff + ang;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ITERS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in_n;
   end

   assign done    = done_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;
endmodule

// File: rtl/kbs_div.sv
module kbs_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [kbs_pkg::DIV_NW-1:0]  num,
   input  logic [kbs_pkg::DIV_DW-1:0]         den,
   output logic                               done,
   output logic signed [kbs_pkg::DIV_NW-1:0]  quo
);
   import kbs_pkg::*;

   localparam int MAG_W = DIV_NW - 1;
   localparam int CW    = $clog2(MAG_W);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [DIV_DW-1:0]    rem_ff, rem_in;
   logic [DIV_DW-1:0]    den_ff, den_in;
   logic [DIV_DW:0]      rem_sh;
   logic [DIV_DW:0]      diff;
   logic                 ge;
   logic signed [DIV_NW-1:0] num_abs;

   assign num_abs = (num < 0) ? -num : num;
   assign rem_sh  = {rem_ff, mag_ff[MAG_W-1]};
   assign diff    = rem_sh - {1'b0, den_ff};
   assign ge      = rem_sh >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         neg_in = num < 0;
         cnt_in = '0;
         mag_in = num_abs[MAG_W-1:0];
         rem_in = '0;
         den_in = den;
      end else if (run_ff) begin
         mag_in = {mag_ff[MAG_W-2:0], ge};
         rem_in = ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(MAG_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
endmodule

// File: rtl/kinematic_bicycle_step_top.sv
// Channel   Direction  Contents
// req_bus   in         cmd, step_time, wheel_accel, steer_rate
// rsp_bus   out        pos_x, pos_y, heading, steer_angle, speed, wheel_speed,
//                      yaw_rate, skipped
// csr_*     in         csr_we, csr_index, csr_wdata (wheel_radius, wheel_base)
//
// A step item runs three divisions on the shared radix-2 divider and two rotations on
// the shared CORDIC before its result becomes valid.
// Stop, reset and skipped items run only the wheel speed division.
// Reset clears the vehicle state and loads 0.25 m radius and 1.5 m wheel base.
// One item is in work at a time; the result holds until its transfer completes.
module kinematic_bicycle_step_top #(
   parameter int CORDIC_ITERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   kbs_req_if.sink     req_bus,
   kbs_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import kbs_pkg::*;

   state_type state_ff, state_in;

   logic [19:0]          radius_ff, radius_in, base_ff, base_in;
   logic signed [31:0]   x_ff, x_in, y_ff, y_in, speed_ff, speed_in;
   logic signed [18:0]   heading_ff, heading_in;
   logic signed [17:0]   steer_ff, steer_in;
   logic signed [17:0]   dt_ff, dt_in;
   logic signed [31:0]   alpha_ff, alpha_in;
   logic signed [20:0]   phi_ff, phi_in;
   logic signed [31:0]   tanq_ff, tanq_in, yaw_ff, yaw_in, ws_ff, ws_in;
   logic                 skipped_ff, skipped_in;
   logic                 fold_ff, fold_in;
   logic signed [Z_W-1:0]    hsum_ff, hsum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;

   logic                       cor_start, cor_done;
   logic signed [Z_W-1:0]      cor_z;
   logic signed [XY_W-1:0]     cor_cos, cor_sin, hc_use, hs_use, tc_clamp;

   logic                       div_start, div_done;
   logic signed [DIV_NW-1:0]   div_num, div_quo;
   logic [DIV_DW-1:0]          div_den;

   logic [19:0]                radius_eff, base_eff;
   logic signed [PROD_W-1:0]   prod_sh16, hsum, st_sum, hwrap_raw, hwrap;
   logic signed [Z_W-1:0]      hz, hz_fold;
   logic                       hz_neg;
   logic                       tiny_dt;

   kbs_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .z_in    (cor_z),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   kbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign radius_eff = (radius_ff == '0) ? 20'd1 : radius_ff;
   assign base_eff   = (base_ff == '0) ? 20'd1 : base_ff;
   assign hc_use     = fold_ff ? -cor_cos : cor_cos;
   assign hs_use     = fold_ff ? -cor_sin : cor_sin;
   assign tc_clamp   = (cor_cos < 1) ? XY_W'(1) : cor_cos;
   assign prod_sh16  = prod_ff >>> FRAC_BITS;
   assign hsum       = PROD_W'(heading_ff) + prod_sh16 + PROD_W'(PI_Q);
   assign st_sum     = PROD_W'(steer_ff) + prod_sh16;
   assign hwrap_raw  = PROD_W'(hsum_ff) - prod_ff;
   assign hz         = Z_W'(heading_ff) <<< WSHIFT;
   assign tiny_dt    = (req_bus.step_time < 18'(SKIP_LIMIT)) &&
                       (req_bus.step_time > -18'(SKIP_LIMIT));
   assign prod_in    = mul_a * mul_b;

   always_comb begin
      hz_neg  = 1'b0;
      hz_fold = hz;
      if (hz > HALF_PI_Q30) begin
         hz_fold = hz - PI_Q30;
         hz_neg  = 1'b1;
      end else if (hz < -HALF_PI_Q30) begin
         hz_fold = hz + PI_Q30;
         hz_neg  = 1'b1;
      end
   end

   // The period estimate is off by at most one, so one correction lands in [0, 2*pi).
   always_comb begin
      hwrap = hwrap_raw;
      if (hwrap_raw < 0) begin
         hwrap = hwrap_raw + PROD_W'(TWO_PI_Q);
      end else if (hwrap_raw >= PROD_W'(TWO_PI_Q)) begin
         hwrap = hwrap_raw - PROD_W'(TWO_PI_Q);
      end
   end

   always_comb begin
      radius_in = radius_ff;
      base_in   = base_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RADIUS: radius_in = csr_wdata;
            REG_BASE:   base_in   = csr_wdata;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      speed_in   = speed_ff;
      heading_in = heading_ff;
      steer_in   = steer_ff;
      dt_in      = dt_ff;
      alpha_in   = alpha_ff;
      phi_in     = phi_ff;
      tanq_in    = tanq_ff;
      yaw_in     = yaw_ff;
      ws_in      = ws_ff;
      skipped_in = skipped_ff;
      fold_in    = fold_ff;
      hsum_in    = hsum_ff;
      mul_a      = MUL_A_W'(speed_ff);
      mul_b      = MUL_B_W'(dt_ff);
      cor_start  = 1'b0;
      cor_z      = Z_W'(steer_ff) <<< WSHIFT;
      div_start  = 1'b0;
      div_num    = DIV_NW'(speed_ff) <<< FRAC_BITS;
      div_den    = DIV_DW'(radius_eff);
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               dt_in      = req_bus.step_time;
               alpha_in   = req_bus.wheel_accel;
               phi_in     = req_bus.steer_rate;
               yaw_in     = '0;
               skipped_in = 1'b0;
               state_in   = ST_WS_DIV;
               case (req_bus.cmd)
                  CMD_STEP: begin
                     if (tiny_dt) begin
                        skipped_in = 1'b1;
                     end else begin
                        state_in = ST_STEER_TRIG;
                     end
                  end
                  CMD_STOP: speed_in = '0;
                  CMD_RESET: begin
                     x_in       = '0;
                     y_in       = '0;
                     speed_in   = '0;
                     heading_in = '0;
                     steer_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_STEER_TRIG: begin
            cor_start = 1'b1;
            state_in  = ST_STEER_WAIT;
         end
         ST_STEER_WAIT: if (cor_done) state_in = ST_TAN_DIV;
         ST_TAN_DIV: begin
            div_start = 1'b1;
            div_num   = DIV_NW'(cor_sin) <<< FRAC_BITS;
            div_den   = tc_clamp[DIV_DW-1:0];
            state_in  = ST_TAN_WAIT;
         end
         ST_TAN_WAIT: begin
            if (div_done) begin
               tanq_in  = div_quo[31:0];
               state_in = ST_YAW_MUL;
            end
         end
         ST_YAW_MUL: begin
            mul_b    = tanq_ff;
            state_in = ST_YAW_DIV;
         end
         ST_YAW_DIV: begin
            div_start = 1'b1;
            div_num   = prod_ff[DIV_NW-1:0];
            div_den   = DIV_DW'(base_eff);
            state_in  = ST_YAW_WAIT;
         end
         ST_YAW_WAIT: begin
            if (div_done) begin
               yaw_in   = sat32(PROD_W'(div_quo));
               state_in = ST_HEAD_TRIG;
            end
         end
         ST_HEAD_TRIG: begin
            cor_start = 1'b1;
            cor_z     = hz_fold;
            fold_in   = hz_neg;
            state_in  = ST_HEAD_WAIT;
         end
         ST_HEAD_WAIT: if (cor_done) state_in = ST_VX_MUL;
         ST_VX_MUL: begin
            mul_b    = hc_use[MUL_B_W-1:0];
            state_in = ST_VXDT_MUL;
         end
         ST_VXDT_MUL: begin
            mul_a    = prod_ff[MUL_A_W+29:30];
            mul_b    = MUL_B_W'(dt_ff);
            state_in = ST_X_UPD;
         end
         ST_X_UPD: begin
            x_in     = sat32(PROD_W'(x_ff) + prod_sh16);
            mul_b    = hs_use[MUL_B_W-1:0];
            state_in = ST_VYDT_MUL;
         end
         ST_VYDT_MUL: begin
            mul_a    = prod_ff[MUL_A_W+29:30];
            mul_b    = MUL_B_W'(dt_ff);
            state_in = ST_Y_UPD;
         end
         ST_Y_UPD: begin
            y_in     = sat32(PROD_W'(y_ff) + prod_sh16);
            mul_a    = MUL_A_W'(alpha_ff);
            mul_b    = $signed(MUL_B_W'(radius_eff));
            state_in = ST_ADT_MUL;
         end
         ST_ADT_MUL: begin
            mul_a    = prod_ff[MUL_A_W+FRAC_BITS-1:FRAC_BITS];
            mul_b    = MUL_B_W'(dt_ff);
            state_in = ST_SPEED_UPD;
         end
         ST_SPEED_UPD: begin
            speed_in = sat32(PROD_W'(speed_ff) + prod_sh16);
            mul_a    = MUL_A_W'(yaw_ff);
            mul_b    = MUL_B_W'(dt_ff);
            state_in = ST_HEAD_RECIP;
         end
         ST_HEAD_RECIP: begin
            hsum_in  = hsum[Z_W-1:0];
            mul_a    = MUL_A_W'(hsum);
            mul_b    = HEAD_RECIP;
            state_in = ST_HEAD_QMUL;
         end
         ST_HEAD_QMUL: begin
            mul_a    = MUL_A_W'($signed(prod_ff[PROD_W-1:HEAD_RECIP_SH]));
            mul_b    = TWO_PI_MUL;
            state_in = ST_HEAD_WRAP;
         end
         ST_HEAD_WRAP: begin
            heading_in = 19'(hwrap - PROD_W'(PI_Q));
            state_in   = ST_STEER_MUL;
         end
         ST_STEER_MUL: begin
            mul_a    = MUL_A_W'(phi_ff);
            mul_b    = MUL_B_W'(dt_ff);
            state_in = ST_STEER_UPD;
         end
         ST_STEER_UPD: begin
            if (st_sum > PROD_W'(STEER_MAX)) begin
               steer_in = STEER_MAX;
            end else if (st_sum < -PROD_W'(STEER_MAX)) begin
               steer_in = -STEER_MAX;
            end else begin
               steer_in = st_sum[17:0];
            end
            state_in = ST_WS_DIV;
         end
         ST_WS_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WS_WAIT;
         end
         ST_WS_WAIT: begin
            if (div_done) begin
               ws_in    = sat32(PROD_W'(div_quo));
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         radius_ff  <= RADIUS_RESET;
         base_ff    <= BASE_RESET;
         x_ff       <= '0;
         y_ff       <= '0;
         speed_ff   <= '0;
         heading_ff <= '0;
         steer_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         radius_ff  <= radius_in;
         base_ff    <= base_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         speed_ff   <= speed_in;
         heading_ff <= heading_in;
         steer_ff   <= steer_in;
      end
      dt_ff      <= dt_in;
      alpha_ff   <= alpha_in;
      phi_ff     <= phi_in;
      tanq_ff    <= tanq_in;
      yaw_ff     <= yaw_in;
      ws_ff      <= ws_in;
      skipped_ff <= skipped_in;
      fold_ff    <= fold_in;
      hsum_ff    <= hsum_in;
      prod_ff    <= prod_in;
   end

   assign rsp_bus.pos_x       = x_ff;
   assign rsp_bus.pos_y       = y_ff;
   assign rsp_bus.heading     = heading_ff;
   assign rsp_bus.steer_angle = steer_ff;
   assign rsp_bus.speed       = speed_ff;
   assign rsp_bus.wheel_speed = ws_ff;
   assign rsp_bus.yaw_rate    = yaw_ff;
   assign rsp_bus.skipped     = skipped_ff;

`include "kinematic_bicycle_step_top_assert.svh"

   `KBS_ASSERT_NEXT(a_busy_after_transfer, req_bus.valid && req_bus.ready, !req_bus.ready && !rsp_bus.valid, "block not busy after an input transfer")
   `KBS_ASSERT_NOW(a_skip_zero_yaw, rsp_bus.valid && skipped_ff, yaw_ff == '0, "skipped step reports a nonzero yaw rate")
   `KBS_ASSERT_NOW(a_heading_range, rsp_bus.valid, heading_ff <= HEADING_MAX && heading_ff >= -HEADING_MAX, "heading out of range")
   `KBS_ASSERT_NOW(a_steer_range, rsp_bus.valid, steer_ff <= STEER_MAX && steer_ff >= -STEER_MAX, "steer angle out of range")

endmodule
